FILE: src/fsps_pkg.sv
// Shared types and constants for the Fourier series point synthesizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package fsps_pkg;

  localparam int unsigned ACC_W = 64;
  localparam int unsigned SIN_STEPS = 4;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;

  // Odd sine polynomial coefficients in Q30, highest degree first.
  localparam logic [30:0] SIN_COEF [SIN_STEPS+1] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
  };

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] REG_TERM_COUNT = 2'd2;

  typedef struct packed {
    logic [15:0] amp;
    logic [7:0]  freq;
    logic [15:0] phase;
  } term_row_t;

  typedef struct packed {
    logic [30:0] p;
    logic [30:0] z;
    logic [30:0] z2;
    logic        neg;
  } horner_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_MAG,
    ST_RND,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: src/fsps_horner_cell.sv
// One Horner step of the sine polynomial: p = coef - (p * z^2 >> 30).
// Depends on fsps_pkg; chained inside fsps_sine_lane.
`default_nettype none

module fsps_horner_cell
  import fsps_pkg::*;
#(
  parameter int unsigned STEP = 1
) (
  input  wire     clk,
  input  horner_t cell_in,
  output horner_t cell_out
);

  logic [61:0] prod;

  assign prod = 62'(cell_in.p) * 62'(cell_in.z2);

  always_ff @(posedge clk) begin
    cell_out.p   <= SIN_COEF[STEP] - prod[60:30];
    cell_out.z   <= cell_in.z;
    cell_out.z2  <= cell_in.z2;
    cell_out.neg <= cell_in.neg;
  end

endmodule

`default_nettype wire

FILE: src/fsps_sine_lane.sv
// Sine of a 32-bit turn fraction, seven registered stages deep.
// Depends on fsps_pkg and a chain of fsps_horner_cell instances.
`default_nettype none

module fsps_sine_lane
  import fsps_pkg::*;
(
  input  wire                clk,
  input  wire  [31:0]        turn,
  output logic signed [31:0] sine
);

  logic [30:0] fold_z;
  logic        fold_neg;
  horner_t     chain [SIN_STEPS+1];
  logic [61:0] zz;
  logic [61:0] pz;
  logic [31:0] mag;

  always_ff @(posedge clk) begin
    fold_neg <= turn[31];
    if (turn[30]) begin
      fold_z <= Q30_ONE - {1'b0, turn[29:0]};
    end else begin
      fold_z <= {1'b0, turn[29:0]};
    end
  end

  assign zz = 62'(fold_z) * 62'(fold_z);

  always_ff @(posedge clk) begin
    chain[0].p   <= SIN_COEF[0];
    chain[0].z   <= fold_z;
    chain[0].z2  <= zz[60:30];
    chain[0].neg <= fold_neg;
  end

  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_cell
    fsps_horner_cell #(.STEP(k + 1)) u_cell (
      .clk      (clk),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  assign pz  = 62'(chain[SIN_STEPS].p) * 62'(chain[SIN_STEPS].z);
  assign mag = (pz[61:30] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : pz[61:30];

  always_ff @(posedge clk) begin
    sine <= chain[SIN_STEPS].neg ? -$signed(mag) : $signed(mag);
  end

endmodule

`default_nettype wire

FILE: src/fourier_series_point_synth.sv
// Epicycle point synthesizer: a load transaction writes one term row; an evaluate transaction
// streams the first n rows (term_count clamped to 2..TERMS) one per cycle through the angle
// stage and two sine lanes, then rounds. Depends on fsps_pkg, fsps_sine_lane.
`default_nettype none

module fourier_series_point_synth
  import fsps_pkg::*;
#(
  parameter int unsigned TERMS      = 256,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                op,
  input  wire  [7:0]         term_index,
  input  wire  [15:0]        amplitude,
  input  wire  signed [7:0]  frequency,
  input  wire  [15:0]        phase_offset,
  input  wire  [15:0]        time_req,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] x_pos,
  output logic signed [31:0] y_pos,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [3:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int unsigned CW = $clog2(TERMS + 1);
  localparam int unsigned LANE_LAT = 7;
  localparam int unsigned PIPE_LEN = LANE_LAT + 3;
  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [8:0]         term_count;

  term_row_t term_mem [TERMS];
  term_row_t mem_q;

  state_t state, state_next;
  logic   issue, accept, fin_load, out_free;

  logic [CW-1:0] cnt;
  logic [CW-1:0] n_terms;
  logic [31:0]   tc_lo;
  logic [31:0]   tc_clamp;
  logic [15:0]   time_q;
  logic [PIPE_LEN-1:0] vpipe;

  logic [15:0] fprod;
  logic [15:0] a16;
  logic [31:0] turn_q;
  logic [17:0] am_q;
  logic [17:0] am_line [LANE_LAT];
  logic signed [31:0] sin_s, cos_s;
  logic signed [50:0] prod_x, prod_y;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic [ACC_W-1:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic [31:0] rq_x, rq_y;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= 16'sd50;
      origin_y   <= 16'sd150;
      term_count <= 9'd2;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ORIGIN_X:   origin_x   <= pwdata[15:0];
        REG_ORIGIN_Y:   origin_y   <= pwdata[15:0];
        REG_TERM_COUNT: term_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ORIGIN_X:   prdata = {{16{origin_x[15]}}, origin_x};
      REG_ORIGIN_Y:   prdata = {{16{origin_y[15]}}, origin_y};
      REG_TERM_COUNT: prdata = {23'd0, term_count};
      default:        prdata = 32'd0;
    endcase
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && op == OP_EVAL) state_next = ST_RUN;
      ST_RUN:   if (cnt == n_terms - CW'(1)) state_next = ST_DRAIN;
      ST_DRAIN: if (vpipe == '0) state_next = ST_MAG;
      ST_MAG:   state_next = ST_RND;
      ST_RND:   state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    issue    = (state == ST_RUN);
    fin_load = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && 32'(term_index) < TERMS) begin
      term_mem[AW'(term_index)] <= '{amp: amplitude, freq: frequency, phase: phase_offset};
    end
    if (issue) begin
      mem_q <= term_mem[cnt[AW-1:0]];
    end
  end

  assign tc_lo    = (term_count < 9'd2) ? 32'd2 : 32'(term_count);
  assign tc_clamp = (tc_lo > TERMS) ? TERMS : tc_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_LEN-2:0], issue};
      if (accept) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_q  <= time_req;
      n_terms <= CW'(tc_clamp);
    end
  end

  assign fprod = 16'({{8{mem_q.freq[7]}}, mem_q.freq} * time_q);
  assign a16   = fprod + mem_q.phase;

  always_ff @(posedge clk) begin
    turn_q     <= {a16, 16'h0000} & ANG_MASK;
    am_q       <= {1'b0, mem_q.amp, 1'b0} + {2'b00, mem_q.amp};
    am_line[0] <= am_q;
    for (int i = 1; i < LANE_LAT; i++) begin
      am_line[i] <= am_line[i-1];
    end
  end

  fsps_sine_lane u_cos (
    .clk  (clk),
    .turn (turn_q + 32'h4000_0000),
    .sine (cos_s)
  );

  fsps_sine_lane u_sin (
    .clk  (clk),
    .turn (turn_q),
    .sine (sin_s)
  );

  always_ff @(posedge clk) begin
    prod_x <= $signed({1'b0, am_line[LANE_LAT-1]}) * cos_s;
    prod_y <= $signed({1'b0, am_line[LANE_LAT-1]}) * sin_s;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (vpipe[PIPE_LEN-1]) begin
      acc_x <= acc_x + ACC_W'(prod_x);
      acc_y <= acc_y + ACC_W'(prod_y);
    end
    if (state == ST_MAG) begin
      neg_x <= acc_x[ACC_W-1];
      neg_y <= acc_y[ACC_W-1];
      mag_x <= acc_x[ACC_W-1] ? -acc_x : acc_x;
      mag_y <= acc_y[ACC_W-1] ? -acc_y : acc_y;
    end
    if (state == ST_RND) begin
      rq_x <= 32'((mag_x + Q30_HALF) >> 30);
      rq_y <= 32'((mag_y + Q30_HALF) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      x_pos <= (neg_x ? -rq_x : rq_x) + {{8{origin_x[15]}}, origin_x, 8'h00};
      y_pos <= (neg_y ? -rq_y : rq_y) + {{8{origin_y[15]}}, origin_y, 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the epicycle point synthesizer: loads term rows, evaluates points
// and compares each point with a fixed-point prediction kept in a small scoreboard class.
// Depends on fsps_pkg and fourier_series_point_synth.
`default_nettype none

module tb
  import fsps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TERMS = 256;
  localparam longint LIMIT = 3000000;

  class point_board;
    logic [15:0] amp_q [N_TERMS];
    logic [7:0]  freq_q [N_TERMS];
    logic [15:0] phase_q [N_TERMS];
    logic [15:0] org_x, org_y;
    logic [8:0]  count;
    logic [31:0] x_exp [$];
    logic [31:0] y_exp [$];
    int errors;
    int points;

    function new();
      org_x = 16'd50;
      org_y = 16'd150;
      count = 9'd2;
      errors = 0;
      points = 0;
    endfunction

    function longint quarter_sine(longint z);
      longint z2, p;
      z2 = (z * z) >>> 30;
      p = 172272;
      p = 5026995 - ((p * z2) >>> 30);
      p = 85569306 - ((p * z2) >>> 30);
      p = 693598669 - ((p * z2) >>> 30);
      p = 1686629713 - ((p * z2) >>> 30);
      p = (p * z) >>> 30;
      return (p > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : p;
    endfunction

    function longint turn_sine(logic [31:0] t);
      longint r, s;
      r = longint'(t[29:0]);
      s = t[30] ? quarter_sine((64'sd1 <<< 30) - r) : quarter_sine(r);
      return t[31] ? -s : s;
    endfunction

    function longint round_fraction(longint v);
      if (v >= 0) return (v + (64'sd1 <<< 29)) >>> 30;
      return -((-v + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function void note_item(logic o, logic [7:0] idx, logic [15:0] a, logic [7:0] f,
                            logic [15:0] ph, logic [15:0] tm);
      int n;
      longint sx, sy, am;
      logic [15:0] ang;
      logic [31:0] t;
      if (o == OP_LOAD) begin
        amp_q[idx] = a;
        freq_q[idx] = f;
        phase_q[idx] = ph;
        return;
      end
      n = count < 2 ? 2 : count > N_TERMS ? N_TERMS : count;
      sx = 0;
      sy = 0;
      for (int j = 0; j < n; j++) begin
        ang = 16'($signed(freq_q[j]) * $signed({1'b0, tm})) + phase_q[j];
        t = {ang, 16'd0};
        am = longint'(amp_q[j]) * 3;
        sx += am * turn_sine(t + 32'h4000_0000);
        sy += am * turn_sine(t);
      end
      x_exp.push_back(32'(longint'($signed(org_x)) * 256 + round_fraction(sx)));
      y_exp.push_back(32'(longint'($signed(org_y)) * 256 + round_fraction(sy)));
    endfunction

    function void check_point(logic [31:0] x, logic [31:0] y);
      logic [31:0] ex, ey;
      points++;
      if (x_exp.size() == 0) begin
        $error("unexpected point x=%0d y=%0d", $signed(x), $signed(y));
        errors++;
        return;
      end
      ex = x_exp.pop_front();
      ey = y_exp.pop_front();
      if (x !== ex) begin
        $error("x_pos expected %0d actual %0d", $signed(ex), $signed(x));
        errors++;
      end
      if (y !== ey) begin
        $error("y_pos expected %0d actual %0d", $signed(ey), $signed(y));
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, op = 0, out_stall = 0;
  logic [7:0] term_index = 0, frequency = 0;
  logic [15:0] amplitude = 0, phase_offset = 0, time_req = 0;
  logic out_valid, in_stall, pready;
  logic signed [31:0] x_pos, y_pos;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  bit quiet = 0;
  longint cycles = 0;
  int sent = 0;
  point_board board;

  always #6 clk = ~clk;

  fourier_series_point_synth i_dut (
    .clk, .rst, .in_valid, .in_stall, .op, .term_index, .amplitude, .frequency,
    .phase_offset, .time_req, .out_valid, .out_stall, .x_pos, .y_pos,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) board.check_point(x_pos, y_pos);
  end

  always @(negedge clk) begin
    if (rst || quiet) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < 29);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_ORIGIN_X: board.org_x = value[15:0];
      REG_ORIGIN_Y: board.org_y = value[15:0];
      default: board.count = value[8:0];
    endcase
  endtask

  task automatic send(logic o, logic [7:0] idx, logic [15:0] a, logic [7:0] f,
                      logic [15:0] ph, logic [15:0] tm);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    op <= o;
    term_index <= idx;
    amplitude <= a;
    frequency <= f;
    phase_offset <= ph;
    time_req <= tm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(o, idx, a, f, ph, tm);
    sent++;
  endtask

  task automatic load_row(logic [7:0] idx);
    send(OP_LOAD, idx, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.x_exp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic eval_point(logic [15:0] tm);
    send(OP_EVAL, 8'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), tm);
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send(OP_LOAD, 8'd0, 16'hFFFF, 8'h7F, 16'hFFFF, 16'h0000);
    send(OP_LOAD, 8'd1, 16'h0000, 8'h80, 16'h0000, 16'hFFFF);
    eval_point(16'h0000);
    eval_point(16'hFFFF);
    send(OP_LOAD, 8'd1, 16'hFFFF, 8'h80, 16'h4000, 16'h1234);
    eval_point(16'h8000);
    eval_point(16'h4000);
    for (int i = 2; i < 256; i++) load_row(8'(i));
    drain();
    write_reg(REG_ORIGIN_X, 32'h0000_8000);
    write_reg(REG_ORIGIN_Y, 32'h0000_7FFF);
    write_reg(REG_TERM_COUNT, 32'd256);
    eval_point(16'h0001);
    eval_point(16'hC000);
    drain();
    write_reg(REG_TERM_COUNT, 32'd0);
    eval_point(16'h2000);
    drain();
    write_reg(REG_TERM_COUNT, 32'd1);
    eval_point(16'hAAAA);
    drain();
    write_reg(REG_TERM_COUNT, 32'd511);
    eval_point(16'h5555);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ORIGIN_X, 32'($urandom));
      write_reg(REG_ORIGIN_Y, 32'($urandom));
      write_reg(REG_TERM_COUNT, ph == 3 ? 32'd256 : 32'($urandom_range(2, 24)));
      quiet = (ph == 1);
      for (int k = 0; k < 260; k++) begin
        if ($urandom_range(99) < 55) eval_point(16'($urandom));
        else if ($urandom_range(9) == 0) send(OP_LOAD, 8'($urandom), 16'($urandom),
                                              8'($urandom), 16'($urandom), 16'($urandom));
        else load_row(8'($urandom_range(0, 31)));
      end
      drain();
    end
    quiet = 0;
    $display("Sent %0d transactions and checked %0d points across several origin and",
             sent, board.points);
    $display("term count settings, including the clamped extremes.");
    if (board.errors == 0 && board.x_exp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
src/fsps_pkg.sv
src/fsps_horner_cell.sv
src/fsps_sine_lane.sv
src/fourier_series_point_synth.sv
tb/sv/tb.sv
